// File: rtl/cgof_pkg.sv
// Package: shared types, codes and constants for the CAN gateway override filter.
package cgof_pkg;

  localparam logic [28:0] AddrBrake   = 29'h315;
  localparam logic [28:0] AddrIgn     = 29'h1F1;
  localparam logic [28:0] AddrUpdate  = 29'h0F0;
  localparam logic [31:0] MagicLow    = 32'hDEADFACE;
  localparam logic [31:0] MagicSoft   = 32'h0AB00B1E;
  localparam logic [31:0] MagicBoot   = 32'h02B00B1E;
  localparam logic [10:0] StatusAddr  = 11'h2FF;
  localparam logic [7:0]  TimeoutReset = 8'd50;
  localparam logic [31:0] StatusLen   = 32'd4;

  typedef enum logic [1:0] {
    CMD_FRAME = 2'd0,
    CMD_ERROR = 2'd1,
    CMD_TICK  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    KIND_FORWARD = 2'd0,
    KIND_STATUS  = 2'd1,
    KIND_SOFT    = 2'd2,
    KIND_BOOT    = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    BUS_0    = 2'd0,
    BUS_1    = 2'd1,
    BUS_2    = 2'd2,
    BUS_NONE = 2'd3
  } bus_e;

  typedef enum logic [1:0] {
    FAULT_NONE    = 2'd0,
    FAULT_ERROR   = 2'd1,
    FAULT_POWERUP = 2'd2
  } fault_e;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [1:0]  source_bus;
    logic [31:0] id_word;
    logic [31:0] length_word;
    logic [31:0] data_low;
    logic [31:0] data_high;
    logic        tx_mailbox_free;
  } item_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [1:0]  dest_bus;
    logic [31:0] out_id_word;
    logic [31:0] out_length_word;
    logic [31:0] out_data_low;
    logic [31:0] out_data_high;
  } result_t;

endpackage

// File: rtl/cgof_decide.sv
// Decision logic and mode/fault state of the gateway filter.
module cgof_decide import cgof_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_data_i,
  input  logic       commit_i,
  input  item_t      item_i,
  output logic       has_result_o,
  output result_t    result_o
);

  logic       brake_override_q, brake_override_d;
  logic       ignition_seen_q, ignition_seen_d;
  logic [7:0] brake_timer_q, brake_timer_d;
  logic [7:0] ignition_timer_q, ignition_timer_d;
  logic [1:0] fault_q [3];
  logic [1:0] fault_d [3];
  logic       phase_q, phase_d;
  logic [7:0] limit_q;

  logic [28:0] addr;
  logic        bus_ok;
  logic [31:0] fwd_id;
  logic [31:0] status_data;

  assign addr   = item_i.id_word[2] ? item_i.id_word[31:3] : {18'd0, item_i.id_word[31:21]};
  assign bus_ok = (item_i.source_bus != BUS_NONE);
  assign fwd_id = item_i.id_word | 32'd1;
  // Bytes 0..2 each carry their bus fault code in bits 5..4; byte 0 also has the override.
  assign status_data = {8'd0,
                        2'd0, fault_q[2], 4'd0,
                        2'd0, fault_q[1], 4'd0,
                        2'd0, fault_q[0], 3'd0, brake_override_q};

  always_comb begin
    brake_override_d = brake_override_q;
    ignition_seen_d  = ignition_seen_q;
    brake_timer_d    = brake_timer_q;
    ignition_timer_d = ignition_timer_q;
    fault_d          = fault_q;
    phase_d          = phase_q;
    has_result_o     = 1'b0;
    result_o         = '{result_kind: KIND_FORWARD, dest_bus: BUS_0,
                         out_id_word: fwd_id, out_length_word: item_i.length_word,
                         out_data_low: item_i.data_low, out_data_high: item_i.data_high};
    case (item_i.cmd)
      CMD_FRAME: begin
        if (bus_ok) begin
          fault_d[item_i.source_bus] = FAULT_NONE;
          case (item_i.source_bus)
            BUS_0: begin
              has_result_o      = 1'b1;
              result_o.dest_bus = BUS_2;
            end
            BUS_2: begin
              // Drop brake commands from bus 2 while override holds.
              has_result_o = !((addr == AddrBrake) && brake_override_q);
            end
            default: begin
              if (addr == AddrUpdate) begin
                has_result_o = 1'b1;
                if ((item_i.data_low == MagicLow) &&
                    ((item_i.data_high == MagicSoft) || (item_i.data_high == MagicBoot))) begin
                  result_o = '0;
                  result_o.result_kind = (item_i.data_high == MagicSoft) ? KIND_SOFT : KIND_BOOT;
                end
              end else if (addr == AddrBrake) begin
                has_result_o     = 1'b1;
                brake_override_d = 1'b1;
                brake_timer_d    = '0;
              end else if (addr == AddrIgn) begin
                ignition_seen_d  = 1'b1;
                ignition_timer_d = '0;
              end
            end
          endcase
        end
      end
      CMD_ERROR: begin
        if (bus_ok) begin
          fault_d[item_i.source_bus] = FAULT_ERROR;
        end
      end
      CMD_TICK: begin
        if (phase_q && ignition_seen_q && item_i.tx_mailbox_free) begin
          has_result_o = 1'b1;
          result_o = '{result_kind: KIND_STATUS, dest_bus: BUS_1,
                       out_id_word: {StatusAddr, 21'd1}, out_length_word: StatusLen,
                       out_data_low: status_data, out_data_high: 32'd0};
        end
        phase_d = !phase_q;
        // Clear the mode once its timer reaches the limit, else advance it.
        if (brake_timer_q >= limit_q) begin
          brake_override_d = 1'b0;
        end else begin
          brake_timer_d = brake_timer_q + 8'd1;
        end
        if (ignition_timer_q >= limit_q) begin
          ignition_seen_d = 1'b0;
        end else begin
          ignition_timer_d = ignition_timer_q + 8'd1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      brake_override_q <= 1'b0;
      ignition_seen_q  <= 1'b0;
      brake_timer_q    <= '0;
      ignition_timer_q <= '0;
      fault_q[0]       <= FAULT_POWERUP;
      fault_q[1]       <= FAULT_POWERUP;
      fault_q[2]       <= FAULT_POWERUP;
      phase_q          <= 1'b0;
      limit_q          <= TimeoutReset;
    end else begin
      if (cfg_we_i) begin
        limit_q <= cfg_data_i;
      end
      if (commit_i) begin
        brake_override_q <= brake_override_d;
        ignition_seen_q  <= ignition_seen_d;
        brake_timer_q    <= brake_timer_d;
        ignition_timer_q <= ignition_timer_d;
        fault_q          <= fault_d;
        phase_q          <= phase_d;
      end
    end
  end

endmodule

// File: rtl/can_gateway_override_filter_top.sv
// Top level of the three-bus CAN gateway with brake-override filter.
//
// Three-bus CAN gateway. Each input item is a received frame, a bus error
// event or a timer tick; each gives at most one result item (forwarded frame,
// bus 1 status frame, or soft/boot reset request). An item is captured in an
// input register, decided by combinational logic against the mode and fault
// state, and the result lands in an output register. Throughput is one item
// per cycle while in_stall_o is low. The input register keeps accepting while
// a result waits in the output register, and stalls only when its held item
// has a result and the output register is still full and stalled. The user
// must write timeout_limit through cfg_we_i/cfg_data_i only while the block
// is idle; the block does not enforce this. Its reset value is 50 ticks.
module can_gateway_override_filter_top import cgof_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  cmd_i,
  input  logic [1:0]  source_bus_i,
  input  logic [31:0] id_word_i,
  input  logic [31:0] length_word_i,
  input  logic [31:0] data_low_i,
  input  logic [31:0] data_high_i,
  input  logic        tx_mailbox_free_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  result_kind_o,
  output logic [1:0]  dest_bus_o,
  output logic [31:0] out_id_word_o,
  output logic [31:0] out_length_word_o,
  output logic [31:0] out_data_low_o,
  output logic [31:0] out_data_high_o
);

  logic    in_valid_q;
  item_t   item_q;
  logic    out_valid_q;
  result_t result_q;

  logic    has_result;
  result_t result;
  logic    out_free;
  logic    advance;
  logic    accept;

  // Output register can take a new result when empty or being drained.
  assign out_free   = !out_valid_q || !out_stall_i;
  // Held item moves on unless it has a result with nowhere to go.
  assign advance    = in_valid_q && (!has_result || out_free);
  assign in_stall_o = in_valid_q && !advance;
  assign accept     = in_valid_i && !in_stall_o;

  cgof_decide u_decide (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_data_i   (cfg_data_i),
    .commit_i     (advance),
    .item_i       (item_q),
    .has_result_o (has_result),
    .result_o     (result)
  );

  // Input register: hold the item until decided.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (accept || advance) begin
      in_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= '{cmd: cmd_i, source_bus: source_bus_i, id_word: id_word_i,
                  length_word: length_word_i, data_low: data_low_i,
                  data_high: data_high_i, tx_mailbox_free: tx_mailbox_free_i};
    end
  end

  // Output register: load a fresh result, drop valid once taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= advance && has_result;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && advance && has_result) begin
      result_q <= result;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign result_kind_o     = result_q.result_kind;
  assign dest_bus_o        = result_q.dest_bus;
  assign out_id_word_o     = result_q.out_id_word;
  assign out_length_word_o = result_q.out_length_word;
  assign out_data_low_o    = result_q.out_data_low;
  assign out_data_high_o   = result_q.out_data_high;

endmodule
